[rtl/rrts_pkg.sv]
// Shared types for the round-robin task scheduler: commands, task states,
// the micro-op and branch codes, the control word and the microprogram ROM.
// No dependencies.
package rrts_pkg;

  typedef enum logic [2:0] {
    CMD_CREATE   = 3'd0,
    CMD_SCHEDULE = 3'd1,
    CMD_BLOCK    = 3'd2,
    CMD_UNBLOCK  = 3'd3,
    CMD_EXIT     = 3'd4,
    CMD_LOCK     = 3'd5,
    CMD_UNLOCK   = 3'd6,
    CMD_QUERY    = 3'd7
  } rrts_cmd_e;

  typedef enum logic [1:0] {
    ST_READY   = 2'd0,
    ST_RUNNING = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_DEAD    = 2'd3
  } rrts_tstate_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CREATE,
    OP_FAIL,
    OP_RD_TID,
    OP_WR_TID_READY,
    OP_LATCH_Q,
    OP_LOCK,
    OP_UNLOCK,
    OP_WR_RUN_DEAD,
    OP_WR_TID_BLOCK,
    OP_SCAN_INIT,
    OP_RD_CAND,
    OP_SCAN_NEXT,
    OP_EMIT,
    OP_RD_RUN,
    OP_WR_RUN_READY,
    OP_SWITCH
  } rrts_op_e;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NEVER,
    C_IN_VALID,
    C_FULL,
    C_NOT_RANGE,
    C_NOT_BLOCKED,
    C_NOT_CUR,
    C_NO_RESCHED,
    C_RUNNABLE,
    C_NOT_LAST,
    C_OUT_FREE,
    C_NOT_RUNNING
  } rrts_cond_e;

  typedef logic [4:0] rrts_upc_t;

  // microprogram step addresses
  localparam rrts_upc_t U_FETCH = 5'd0;
  localparam rrts_upc_t U_CR0   = 5'd1;
  localparam rrts_upc_t U_CR1   = 5'd2;
  localparam rrts_upc_t U_FAIL  = 5'd3;
  localparam rrts_upc_t U_UB0   = 5'd4;
  localparam rrts_upc_t U_UB1   = 5'd5;
  localparam rrts_upc_t U_UB2   = 5'd6;
  localparam rrts_upc_t U_QY0   = 5'd7;
  localparam rrts_upc_t U_QY1   = 5'd8;
  localparam rrts_upc_t U_LK    = 5'd9;
  localparam rrts_upc_t U_UL    = 5'd10;
  localparam rrts_upc_t U_EX0   = 5'd11;
  localparam rrts_upc_t U_BK0   = 5'd12;
  localparam rrts_upc_t U_BK1   = 5'd13;
  localparam rrts_upc_t U_RS0   = 5'd14;
  localparam rrts_upc_t U_RS1   = 5'd15;
  localparam rrts_upc_t U_RS2   = 5'd16;
  localparam rrts_upc_t U_RS3   = 5'd17;
  localparam rrts_upc_t U_EMIT  = 5'd18;
  localparam rrts_upc_t U_SW0   = 5'd19;
  localparam rrts_upc_t U_SW1   = 5'd20;
  localparam rrts_upc_t U_SW2   = 5'd21;
  localparam rrts_upc_t U_SW3   = 5'd22;

  // Branch taken: go to target (or dispatch on the command). Not taken:
  // hold in place or fall through to the next step.
  typedef struct packed {
    logic       accept;
    rrts_op_e   op;
    rrts_cond_e cond;
    logic       dispatch;
    logic       hold;
    rrts_upc_t  target;
  } rrts_uword_t;

  typedef struct packed {
    logic      in_valid;
    rrts_cmd_e cmd;
    logic      full;
    logic      not_range;
    logic      not_blocked;
    logic      not_cur;
    logic      no_resched;
    logic      runnable;
    logic      not_last;
    logic      out_free;
    logic      not_running;
  } rrts_flags_t;

  function automatic rrts_uword_t rrts_uw(input rrts_op_e op, input rrts_cond_e cond,
                                          input rrts_upc_t tgt);
    rrts_uword_t w;
    w.accept   = 1'b0;
    w.op       = op;
    w.cond     = cond;
    w.dispatch = 1'b0;
    w.hold     = 1'b0;
    w.target   = tgt;
    return w;
  endfunction

  function automatic rrts_uword_t rrts_urom(input rrts_upc_t a);
    rrts_uword_t w;
    unique case (a)
      U_FETCH: begin
        w          = rrts_uw(OP_NOP, C_IN_VALID, U_FETCH);
        w.accept   = 1'b1;
        w.dispatch = 1'b1;
        w.hold     = 1'b1;
      end
      U_CR0:   w = rrts_uw(OP_NOP,          C_FULL,        U_FAIL);
      U_CR1:   w = rrts_uw(OP_CREATE,       C_ALWAYS,      U_EMIT);
      U_FAIL:  w = rrts_uw(OP_FAIL,         C_ALWAYS,      U_EMIT);
      U_UB0:   w = rrts_uw(OP_RD_TID,       C_NOT_RANGE,   U_FAIL);
      U_UB1:   w = rrts_uw(OP_NOP,          C_NOT_BLOCKED, U_EMIT);
      U_UB2:   w = rrts_uw(OP_WR_TID_READY, C_ALWAYS,      U_EMIT);
      U_QY0:   w = rrts_uw(OP_RD_TID,       C_NOT_RANGE,   U_FAIL);
      U_QY1:   w = rrts_uw(OP_LATCH_Q,      C_ALWAYS,      U_EMIT);
      U_LK:    w = rrts_uw(OP_LOCK,         C_ALWAYS,      U_EMIT);
      U_UL:    w = rrts_uw(OP_UNLOCK,       C_ALWAYS,      U_EMIT);
      U_EX0:   w = rrts_uw(OP_WR_RUN_DEAD,  C_ALWAYS,      U_RS0);
      U_BK0:   w = rrts_uw(OP_NOP,          C_NOT_RANGE,   U_FAIL);
      U_BK1:   w = rrts_uw(OP_WR_TID_BLOCK, C_NOT_CUR,     U_EMIT);
      U_RS0:   w = rrts_uw(OP_SCAN_INIT,    C_NO_RESCHED,  U_EMIT);
      U_RS1:   w = rrts_uw(OP_RD_CAND,      C_NEVER,       U_FETCH);
      U_RS2:   w = rrts_uw(OP_NOP,          C_RUNNABLE,    U_SW0);
      U_RS3:   w = rrts_uw(OP_SCAN_NEXT,    C_NOT_LAST,    U_RS1);
      U_EMIT: begin
        w      = rrts_uw(OP_EMIT, C_OUT_FREE, U_FETCH);
        w.hold = 1'b1;
      end
      U_SW0:   w = rrts_uw(OP_RD_RUN,       C_NEVER,       U_FETCH);
      U_SW1:   w = rrts_uw(OP_NOP,          C_NOT_RUNNING, U_SW3);
      U_SW2:   w = rrts_uw(OP_WR_RUN_READY, C_NEVER,       U_FETCH);
      U_SW3:   w = rrts_uw(OP_SWITCH,       C_ALWAYS,      U_EMIT);
      default: w = rrts_uw(OP_NOP,          C_ALWAYS,      U_FETCH);
    endcase
    return w;
  endfunction

  function automatic rrts_upc_t rrts_dispatch(input rrts_cmd_e cmd);
    rrts_upc_t a;
    unique case (cmd)
      CMD_CREATE:   a = U_CR0;
      CMD_SCHEDULE: a = U_RS0;
      CMD_BLOCK:    a = U_BK0;
      CMD_UNBLOCK:  a = U_UB0;
      CMD_EXIT:     a = U_EX0;
      CMD_LOCK:     a = U_LK;
      CMD_UNLOCK:   a = U_UL;
      CMD_QUERY:    a = U_QY0;
      default:      a = U_FETCH;
    endcase
    return a;
  endfunction

endpackage

[rtl/round_robin_task_scheduler.sv]
// Round-robin task scheduler: a task state table with create, schedule,
// block, unblock, exit, lock, unlock and query commands, one result word per
// command word. Control runs from a microcode ROM (rrts_useq) over a datapath
// whose task table sits in one RAM (rrts_ram) with a single registered read
// port. A command word runs through its microcode steps before its result
// word is loaded into the output register; where it reschedules, the scan
// steps through the slots in turn, each with a RAM read, a check and an
// advance. The output load waits while an earlier result word is stalled.
// The next command word is taken in the cycle after the result word is
// loaded, even while that word still waits at the output. No clearing pass
// after reset: slots at or above the task count are never used, and slot 0
// reads as running until first written.
module round_robin_task_scheduler import rrts_pkg::*; #(
  parameter int TASK_SLOTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] command_i,
  input  logic [3:0] task_id_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] run_task_o,
  output logic [4:0] task_total_o,
  output logic [3:0] new_task_id_o,
  output logic       switched_o,
  output logic [1:0] queried_state_o,
  output logic       failed_o
);

  localparam int IDX_W = $clog2(TASK_SLOTS);
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);

  rrts_uword_t ctrl;
  rrts_flags_t flags;

  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] run_q;
  logic             locked_q;
  logic             slot0_init_q;
  logic             out_valid_q;

  logic [3:0]       tid_q;
  logic [IDX_W-1:0] cand_q;
  logic [CNT_W-1:0] scan_i_q;
  logic             rd_zero_q;
  logic             sw_q;
  logic             fail_q;
  logic [3:0]       newid_q;
  logic [1:0]       qstate_q;

  logic [3:0] cur_out_q;
  logic [4:0] total_out_q;
  logic [3:0] newid_out_q;
  logic       sw_out_q;
  logic [1:0] qstate_out_q;
  logic       fail_out_q;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [1:0]       ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [1:0]       ram_rdata;

  logic             in_accept;
  logic             out_free;
  logic             emit_load;
  logic [IDX_W-1:0] tid_idx;
  logic [CNT_W-1:0] run_inc;
  logic [CNT_W-1:0] cand_inc;
  logic [IDX_W-1:0] cand_init;
  logic [IDX_W-1:0] cand_next;
  logic [31:0]      count_ext;
  logic [31:0]      run_ext;
  logic [31:0]      tid_ext;
  rrts_tstate_e     st_rd;

  assign in_stall_o = !ctrl.accept;
  assign in_accept  = in_valid_i && ctrl.accept;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_load  = (ctrl.op == OP_EMIT) && out_free;

  assign count_ext = 32'(count_q);
  assign run_ext   = 32'(run_q);
  assign tid_ext   = 32'(tid_q);
  assign tid_idx   = IDX_W'(tid_q);

  assign run_inc   = CNT_W'(run_q) + CNT_W'(1);
  assign cand_inc  = CNT_W'(cand_q) + CNT_W'(1);
  assign cand_init = (run_inc == count_q) ? '0 : run_inc[IDX_W-1:0];
  assign cand_next = (cand_inc == count_q) ? '0 : cand_inc[IDX_W-1:0];

  // slot 0 holds "running" from reset until its first write
  assign st_rd = rrts_tstate_e'(rd_zero_q ? ST_RUNNING : ram_rdata);

  always_comb begin
    flags.in_valid    = in_valid_i;
    flags.cmd         = rrts_cmd_e'(command_i);
    flags.full        = count_q >= CNT_W'(TASK_SLOTS);
    flags.not_range   = !(tid_ext < count_ext);
    flags.not_blocked = st_rd != ST_BLOCKED;
    flags.not_cur     = tid_ext != run_ext;
    flags.no_resched  = locked_q || (count_q < CNT_W'(2));
    flags.runnable    = (st_rd == ST_READY) || (st_rd == ST_RUNNING);
    flags.not_last    = scan_i_q != (count_q - CNT_W'(1));
    flags.out_free    = out_free;
    flags.not_running = st_rd != ST_RUNNING;
  end

  rrts_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ST_READY;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (ctrl.op)
      OP_CREATE: begin
        ram_we    = 1'b1;
        ram_waddr = count_q[IDX_W-1:0];
        ram_wdata = ST_READY;
      end
      OP_WR_TID_READY: begin
        ram_we    = 1'b1;
        ram_waddr = tid_idx;
        ram_wdata = ST_READY;
      end
      OP_WR_TID_BLOCK: begin
        ram_we    = 1'b1;
        ram_waddr = tid_idx;
        ram_wdata = ST_BLOCKED;
      end
      OP_WR_RUN_DEAD: begin
        ram_we    = 1'b1;
        ram_waddr = run_q;
        ram_wdata = ST_DEAD;
      end
      OP_WR_RUN_READY: begin
        ram_we    = 1'b1;
        ram_waddr = run_q;
        ram_wdata = ST_READY;
      end
      OP_SWITCH: begin
        ram_we    = 1'b1;
        ram_waddr = cand_q;
        ram_wdata = ST_RUNNING;
      end
      OP_RD_TID: begin
        ram_re    = 1'b1;
        ram_raddr = tid_idx;
      end
      OP_RD_CAND: begin
        ram_re    = 1'b1;
        ram_raddr = cand_q;
      end
      OP_RD_RUN: begin
        ram_re    = 1'b1;
        ram_raddr = run_q;
      end
      default: begin
      end
    endcase
  end

  rrts_ram #(
    .WIDTH (2),
    .DEPTH (TASK_SLOTS)
  ) u_task_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= CNT_W'(1);
      run_q        <= '0;
      locked_q     <= 1'b0;
      slot0_init_q <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      if (ctrl.op == OP_CREATE) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (ctrl.op == OP_SWITCH) begin
        run_q <= cand_q;
      end
      if (ctrl.op == OP_LOCK) begin
        locked_q <= 1'b1;
      end
      if (ctrl.op == OP_UNLOCK) begin
        locked_q <= 1'b0;
      end
      if (ram_we && (ram_waddr == '0)) begin
        slot0_init_q <= 1'b0;
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      tid_q    <= task_id_i;
      sw_q     <= 1'b0;
      fail_q   <= 1'b0;
      newid_q  <= '0;
      qstate_q <= '0;
    end
    if (ram_re) begin
      rd_zero_q <= (ram_raddr == '0) && slot0_init_q;
    end
    unique case (ctrl.op)
      OP_CREATE:    newid_q  <= count_ext[3:0];
      OP_FAIL:      fail_q   <= 1'b1;
      OP_LATCH_Q:   qstate_q <= st_rd;
      OP_SWITCH:    sw_q     <= 1'b1;
      OP_SCAN_INIT: begin
        cand_q   <= cand_init;
        scan_i_q <= CNT_W'(1);
      end
      OP_SCAN_NEXT: begin
        cand_q   <= cand_next;
        scan_i_q <= scan_i_q + CNT_W'(1);
      end
      default: begin
      end
    endcase
    if (emit_load) begin
      cur_out_q    <= run_ext[3:0];
      total_out_q  <= count_ext[4:0];
      newid_out_q  <= newid_q;
      sw_out_q     <= sw_q;
      qstate_out_q <= qstate_q;
      fail_out_q   <= fail_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign run_task_o      = cur_out_q;
  assign task_total_o    = total_out_q;
  assign new_task_id_o   = newid_out_q;
  assign switched_o      = sw_out_q;
  assign queried_state_o = qstate_out_q;
  assign failed_o        = fail_out_q;

  // running slot always lies inside the created range
  assert property (@(posedge clk_i) disable iff (!rst_ni) run_ext < count_ext)
    else $error("running slot outside task count");

  // task count only ever steps up by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> count_q == CNT_W'($past(count_q) + CNT_W'(1)))
    else $error("task count changed by other than one");

  // a switch always moves to a different slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_SWITCH) |-> (cand_q != run_q))
    else $error("switch to the running slot");

  // one command word at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_accept |=> in_stall_o)
    else $error("second word accepted while busy");

endmodule

[rtl/rrts_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rrts_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[rtl/rrts_useq.sv]
// Microcode sequencer: step counter, control ROM lookup and branch logic.
// Depends on rrts_pkg.
module rrts_useq import rrts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rrts_flags_t flags_i,
  output rrts_uword_t ctrl_o
);

  rrts_upc_t upc_q, upc_d;
  logic      take;

  assign ctrl_o = rrts_urom(upc_q);

  always_comb begin
    unique case (ctrl_o.cond)
      C_ALWAYS:      take = 1'b1;
      C_NEVER:       take = 1'b0;
      C_IN_VALID:    take = flags_i.in_valid;
      C_FULL:        take = flags_i.full;
      C_NOT_RANGE:   take = flags_i.not_range;
      C_NOT_BLOCKED: take = flags_i.not_blocked;
      C_NOT_CUR:     take = flags_i.not_cur;
      C_NO_RESCHED:  take = flags_i.no_resched;
      C_RUNNABLE:    take = flags_i.runnable;
      C_NOT_LAST:    take = flags_i.not_last;
      C_OUT_FREE:    take = flags_i.out_free;
      C_NOT_RUNNING: take = flags_i.not_running;
      default:       take = 1'b0;
    endcase
  end

  always_comb begin
    priority if (take && ctrl_o.dispatch) begin
      upc_d = rrts_dispatch(flags_i.cmd);
    end else if (take) begin
      upc_d = ctrl_o.target;
    end else if (ctrl_o.hold) begin
      upc_d = upc_q;
    end else begin
      upc_d = upc_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule
